// ===== design/mexp_pkg.sv =====
// Package for the modular exponentiation block: working width, reset modulus,
// and the request/response structs between the sequencer and the multiplier.
// No dependencies.
`default_nettype none

package mexp_pkg;

    localparam int WIDTH = 64;
    localparam int CNT_W = $clog2(WIDTH);

    localparam logic [WIDTH-1:0] RESET_MODULUS = WIDTH'(64'd1465129870107858983);

    // Request to the bit-serial modular multiplier: x is scanned MSB first.
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] x;
        logic [WIDTH-1:0] y;
    } mul_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [WIDTH-1:0] prod;
    } mul_rsp_t;

endpackage

`default_nettype wire

// ===== design/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: modulus register, exponent
// sequencer and output register. Depends on mexp_pkg and mexp_mulmod.
//
// Usage:
//   Input channel (in_valid/in_ready, base, exponent) takes one request when
//   the block is idle. Output channel (out_valid/out_ready, power) returns
//   base^exponent mod modulus, one result per request.
//   modulus is written by modulus_we/modulus; write it only while idle.
//   A zero modulus returns power = 0.
// Sequence (accept to out_valid): the base is first reduced by one pass of the
//   bit-serial multiplier. Each set exponent bit then costs one multiply and each
//   bit below the highest set bit one squaring, each dispatched from S_NEXT; the
//   output register is then loaded. A zero exponent needs only the reduction
//   and a zero modulus skips the multiplier altogether.
//   The single shared multiplier, one bit per cycle, sets the run time.
// Throughput: one request at a time; in_ready is high only when idle.
// Stall: a finished result is held in the output register; the sequencer
//   returns to idle and takes the next request while the result waits. If the
//   next result completes before the first is taken, the sequencer waits.
// Reset: rst_n (async, active low) clears control and loads the default
//   modulus; no result is pending after reset.
`default_nettype none

module modular_exponentiation (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        modulus_we,
    input  wire logic [mexp_pkg::WIDTH-1:0]  modulus,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [mexp_pkg::WIDTH-1:0]  base,
    input  wire logic [mexp_pkg::WIDTH-1:0]  exponent,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mexp_pkg::WIDTH-1:0]       power
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
    localparam logic [2:0] S_RED  = 3'd1;  // base mod m on the multiplier
    localparam logic [2:0] S_NEXT = 3'd2;  // pick next operation or finish
    localparam logic [2:0] S_MULA = 3'd3;  // acc = acc * sq
    localparam logic [2:0] S_SQR  = 3'd4;  // sq = sq * sq

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [mexp_pkg::WIDTH-1:0] modulus_reg;
    logic [mexp_pkg::WIDTH-1:0] e_reg;
    logic [mexp_pkg::WIDTH-1:0] acc_reg;
    logic [mexp_pkg::WIDTH-1:0] sq_reg;
    logic [mexp_pkg::WIDTH-1:0] power_reg;
    logic                       out_valid_reg;

    logic [mexp_pkg::WIDTH-1:0] one_mod;
    logic                       mod_zero;
    logic                       accept;
    logic                       out_free;
    logic                       load_out;

    mexp_pkg::mul_req_t         req;
    mexp_pkg::mul_rsp_t         rsp;

    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (req),
        .rsp     (rsp)
    );

    // 1 mod m: zero when m is 1 (or 0, which forces a zero result anyway)
    assign one_mod  = {{(mexp_pkg::WIDTH-1){1'b0}},
                       (modulus_reg > mexp_pkg::WIDTH'(1))};
    assign mod_zero = (modulus_reg == '0);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        req.start  = 1'b0;
        req.x      = sq_reg;
        req.y      = sq_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mod_zero)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        // reduce base: base * 1 mod m
                        req.start  = 1'b1;
                        req.x      = base;
                        req.y      = one_mod;
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (rsp.done)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (e_reg == '0)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (e_reg[0])
                begin
                    req.start  = 1'b1;
                    req.x      = acc_reg;
                    state_next = S_MULA;
                end
                else
                begin
                    req.start  = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_MULA:
            begin
                if (rsp.done)
                begin
                    state_next = S_NEXT;
                end
            end
            S_SQR:
            begin
                if (rsp.done)
                begin
                    state_next = S_NEXT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= mexp_pkg::RESET_MODULUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            e_reg   <= mod_zero ? '0 : exponent;
            acc_reg <= mod_zero ? '0 : one_mod;
        end
        if (state_reg == S_RED && rsp.done)
        begin
            sq_reg <= rsp.prod;
        end
        if (state_reg == S_MULA && rsp.done)
        begin
            acc_reg <= rsp.prod;
            e_reg   <= {e_reg[mexp_pkg::WIDTH-1:1], 1'b0};
        end
        if (state_reg == S_SQR && rsp.done)
        begin
            sq_reg <= rsp.prod;
            e_reg  <= {1'b0, e_reg[mexp_pkg::WIDTH-1:1]};
        end
        if (load_out)
        begin
            power_reg <= acc_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign power     = power_reg;

`ifndef SYNTHESIS
    // result is always reduced
    a_power_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !mod_zero |-> power_reg < modulus_reg)
        else $error("power not below modulus");

    // multiplier only runs while the sequencer waits on it
    a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.busy || rsp.done |->
            (state_reg == S_RED || state_reg == S_MULA || state_reg == S_SQR))
        else $error("multiplier active outside a multiply state");

    // each squaring consumes exactly one exponent bit
    a_exp_shift: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQR && rsp.done |=> e_reg == ($past(e_reg) >> 1))
        else $error("exponent not shifted after squaring");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !out_valid_reg || out_ready)
        else $error("result overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== design/mexp_mulmod.sv =====
// Interleaved bit-serial modular multiplier: (x * y) mod m, one bit of x per cycle.
// x need not be reduced; y must be below m. Depends on mexp_pkg.
`default_nettype none

module mexp_mulmod (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [mexp_pkg::WIDTH-1:0]  modulus,
    input  wire mexp_pkg::mul_req_t          req,
    output mexp_pkg::mul_rsp_t               rsp
);

    logic [mexp_pkg::WIDTH-1:0] x_reg;
    logic [mexp_pkg::WIDTH-1:0] y_reg;
    logic [mexp_pkg::WIDTH-1:0] acc_reg;
    logic [mexp_pkg::WIDTH-1:0] acc_next;
    logic [mexp_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [mexp_pkg::WIDTH+1:0] sum;
    logic [mexp_pkg::WIDTH+1:0] m1;
    logic [mexp_pkg::WIDTH+1:0] m2;

    // acc = 2*acc + bit*y, below 3m; take off m or 2m
    always_comb
    begin
        m1  = {2'b00, modulus};
        m2  = {1'b0, modulus, 1'b0};
        sum = {1'b0, acc_reg, 1'b0}
            + (x_reg[mexp_pkg::WIDTH-1] ? {2'b00, y_reg} : '0);
        if (sum >= m2)
        begin
            acc_next = mexp_pkg::WIDTH'(sum - m2);
        end
        else if (sum >= m1)
        begin
            acc_next = mexp_pkg::WIDTH'(sum - m1);
        end
        else
        begin
            acc_next = mexp_pkg::WIDTH'(sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the last bit
            done_reg <= !req.start && busy_reg && (cnt_reg == '0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= mexp_pkg::CNT_W'(mexp_pkg::WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= req.x;
            y_reg   <= req.y;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= {x_reg[mexp_pkg::WIDTH-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire
